@@ rtl/core/lkct_pkg.sv @@
// Package for the keyed LRU cache table: field widths, opcodes, defaults
// and the command/status structs between controller and datapath.
// No dependencies.
package lkct_pkg;

   // Field widths of the request and response transactions
   localparam int OPCODE_W     = 1;
   localparam int KEY_FIELD_W  = 64;
   localparam int HANDLE_FIELD_W = 32;
   localparam int HITS_W       = 32;
   localparam int SLOT_FIELD_W = 6;
   localparam int FILL_FIELD_W = 7;
   localparam int STAMP_W      = 32;

   // Width used when resizing an index or count onto a response field
   localparam int WIDE_W = 16;

   // Parameter defaults for the top level
   localparam int DEF_ENTRIES      = 64;
   localparam int DEF_KEY_WIDTH    = 64;
   localparam int DEF_HANDLE_WIDTH = 32;

   // Opcodes
   localparam logic [OPCODE_W-1:0] OP_LOOKUP = 1'b0;
   localparam logic [OPCODE_W-1:0] OP_INSERT = 1'b1;

   // Controller to datapath
   typedef struct packed {
      logic accept;      // capture the request
      logic start;       // resolve the path for the captured request
      logic issue_en;    // allow slot reads
      logic compare_en;  // evaluate returned slot data
      logic write_en;    // write the chosen slot, update counters
      logic finish;      // load the response register
   } lkct_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic need_scan;     // lookup in a non-empty table, or insert into a full one
      logic direct_write;  // insert with a free slot left
      logic scan_done;     // scan ends this cycle
      logic scan_write;    // scan found a hit or a victim
      logic rsp_free;      // response register can take a new result
      logic full;          // every slot filled
   } lkct_status_type;

endpackage

@@ rtl/core/lkct_req_if.sv @@
// Request channel of the keyed LRU cache table: valid/ready plus payload.
// Depends on lkct_pkg.
interface lkct_req_if;
   import lkct_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [OPCODE_W-1:0]       opcode;
   logic [KEY_FIELD_W-1:0]    key;
   logic [HANDLE_FIELD_W-1:0] data_handle;

   modport source (output valid, output opcode, output key, output data_handle,
                   input ready);
   modport sink   (input valid, input opcode, input key, input data_handle,
                   output ready);
endinterface

@@ rtl/core/lkct_rsp_if.sv @@
// Response channel of the keyed LRU cache table: valid/ready plus payload.
// Depends on lkct_pkg.
interface lkct_rsp_if;
   import lkct_pkg::*;

   logic                      valid;
   logic                      ready;
   logic                      hit;
   logic [HANDLE_FIELD_W-1:0] data_out;
   logic [HITS_W-1:0]         entry_hits;
   logic [SLOT_FIELD_W-1:0]   slot;
   logic                      replaced;
   logic [FILL_FIELD_W-1:0]   fill_level;

   modport source (output valid, output hit, output data_out, output entry_hits,
                   output slot, output replaced, output fill_level, input ready);
   modport sink   (input valid, input hit, input data_out, input entry_hits,
                   input slot, input replaced, input fill_level, output ready);
endinterface

@@ rtl/core/lru_keyed_cache_table_core.sv @@
// Top level of the keyed LRU cache table: controller, datapath, assertions.
// Depends on lkct_pkg, lkct_req_if, lkct_rsp_if, lkct_ctrl, lkct_dpath.
//
// Channel   Dir   Handshake      Payload
// req_chan  in    valid/ready    opcode, key, data_handle
// rsp_chan  out   valid/ready    hit, data_out, entry_hits, slot, replaced, fill_level
//
// One request at a time. An insert with a free slot writes it directly; a
// lookup in a non-empty table or an insert into a full one first scans the
// slots, one RAM word per cycle, and a hit or victim is then written; a miss
// writes nothing. The next request is taken once the response is loaded.
// Synchronous active-high reset empties the table and zeroes the stamp; no
// clearing pass. A stalled response holds the current request in its final state.
module lru_keyed_cache_table_core #(
   parameter int ENTRIES      = lkct_pkg::DEF_ENTRIES,
   parameter int KEY_WIDTH    = lkct_pkg::DEF_KEY_WIDTH,
   parameter int HANDLE_WIDTH = lkct_pkg::DEF_HANDLE_WIDTH
) (
   input logic        clock,
   input logic        reset,
   lkct_req_if.sink   req_chan,
   lkct_rsp_if.source rsp_chan
);
   import lkct_pkg::*;

   lkct_cmd_type    cmd;
   lkct_status_type status;
   logic            req_ready;

   lkct_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   lkct_dpath #(
      .ENTRIES      (ENTRIES),
      .KEY_WIDTH    (KEY_WIDTH),
      .HANDLE_WIDTH (HANDLE_WIDTH)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_opcode      (req_chan.opcode),
      .req_key         (req_chan.key),
      .req_data_handle (req_chan.data_handle),
      .rsp_valid       (rsp_chan.valid),
      .rsp_ready       (rsp_chan.ready),
      .rsp_hit         (rsp_chan.hit),
      .rsp_data_out    (rsp_chan.data_out),
      .rsp_entry_hits  (rsp_chan.entry_hits),
      .rsp_slot        (rsp_chan.slot),
      .rsp_replaced    (rsp_chan.replaced),
      .rsp_fill_level  (rsp_chan.fill_level)
   );

   assign req_chan.ready = req_ready;

   // Only one transaction in flight
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> !req_chan.ready)
      else $error("request accepted while another is in flight");

   // A slot write is always followed by the response stage
   a_write_then_finish: assert property (@(posedge clock) disable iff (reset)
      cmd.write_en |=> !cmd.write_en && !req_chan.ready)
      else $error("slot write not followed by response stage");

   // Eviction only ever happens in a full table
   a_replace_when_full: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.replaced |-> status.full)
      else $error("eviction reported with a free slot left");

endmodule

@@ rtl/core/lkct_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lkct_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/lkct_ctrl.sv @@
// Controller of the keyed LRU cache table: sequences capture, slot scan,
// slot write and response load. Depends on lkct_pkg.
module lkct_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  lkct_pkg::lkct_status_type status,
   output lkct_pkg::lkct_cmd_type    cmd
);
   import lkct_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_START  = 3'd1;
   localparam logic [2:0] S_SCAN   = 3'd2;
   localparam logic [2:0] S_WRITE  = 3'd3;
   localparam logic [2:0] S_FINISH = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   // Next state and commands
   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      req_ready      = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
            if (req_valid) begin
               state_in = S_START;
            end
         end
         S_START: begin
            cmd.start    = 1'b1;
            cmd.issue_en = status.need_scan;
            if (status.direct_write) begin
               state_in = S_WRITE;
            end else if (status.need_scan) begin
               state_in = S_SCAN;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_SCAN: begin
            cmd.issue_en   = 1'b1;
            cmd.compare_en = 1'b1;
            if (status.scan_done) begin
               state_in = status.scan_write ? S_WRITE : S_FINISH;
            end
         end
         S_WRITE: begin
            cmd.write_en = 1'b1;
            state_in     = S_FINISH;
         end
         S_FINISH: begin
            cmd.finish = status.rsp_free;
            if (status.rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/core/lkct_dpath.sv @@
// Datapath of the keyed LRU cache table: slot RAM, scan pipeline, oldest
// stamp tracking, counters and response register. Depends on lkct_pkg, lkct_ram.
module lkct_dpath #(
   parameter int ENTRIES      = lkct_pkg::DEF_ENTRIES,
   parameter int KEY_WIDTH    = lkct_pkg::DEF_KEY_WIDTH,
   parameter int HANDLE_WIDTH = lkct_pkg::DEF_HANDLE_WIDTH
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  lkct_pkg::lkct_cmd_type                 cmd,
   output lkct_pkg::lkct_status_type              status,
   input  logic [lkct_pkg::OPCODE_W-1:0]          req_opcode,
   input  logic [lkct_pkg::KEY_FIELD_W-1:0]       req_key,
   input  logic [lkct_pkg::HANDLE_FIELD_W-1:0]    req_data_handle,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic                                   rsp_hit,
   output logic [lkct_pkg::HANDLE_FIELD_W-1:0]    rsp_data_out,
   output logic [lkct_pkg::HITS_W-1:0]            rsp_entry_hits,
   output logic [lkct_pkg::SLOT_FIELD_W-1:0]      rsp_slot,
   output logic                                   rsp_replaced,
   output logic [lkct_pkg::FILL_FIELD_W-1:0]      rsp_fill_level
);
   import lkct_pkg::*;

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);

   // Slot word layout: {stamp, hits, handle, key}
   localparam int KEY_LO    = 0;
   localparam int HANDLE_LO = KEY_WIDTH;
   localparam int HITS_LO   = HANDLE_LO + HANDLE_WIDTH;
   localparam int STAMP_LO  = HITS_LO + HITS_W;
   localparam int WORD_W    = STAMP_LO + STAMP_W;

   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(ENTRIES);

   // Captured request
   logic [OPCODE_W-1:0]     op_ff;
   logic [KEY_WIDTH-1:0]    key_ff;
   logic [HANDLE_WIDTH-1:0] handle_ff;

   // Persistent state
   logic [CNT_W-1:0]   filled_ff, filled_in;
   logic [STAMP_W-1:0] stamp_ff, stamp_in;

   // Scan pipeline
   logic [CNT_W-1:0]   rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0]   cmp_idx_ff;
   logic               cmp_valid_ff, cmp_valid_in;
   logic [IDX_W-1:0]   best_idx_ff, best_idx_in;
   logic [STAMP_W-1:0] best_stamp_ff, best_stamp_in;

   // Per-request results
   logic                    found_ff, found_in;
   logic [HANDLE_WIDTH-1:0] found_handle_ff, found_handle_in;
   logic [HITS_W-1:0]       found_hits_ff, found_hits_in;
   logic [IDX_W-1:0]        target_ff, target_in;
   logic                    replaced_ff, replaced_in;

   // Response register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_hit_ff;
   logic [HANDLE_FIELD_W-1:0] rsp_data_ff;
   logic [HITS_W-1:0]         rsp_hits_ff;
   logic [SLOT_FIELD_W-1:0]   rsp_slot_ff;
   logic                      rsp_repl_ff;
   logic [FILL_FIELD_W-1:0]   rsp_fill_ff;

   // RAM signals
   logic              ram_wr_en;
   logic [WORD_W-1:0] ram_wr_data;
   logic [WORD_W-1:0] ram_rd_data;

   logic [KEY_FIELD_W-1:0] req_key_wide;
   logic [63:0]            req_handle_wide;
   logic [63:0]            found_handle_wide;
   logic [WIDE_W-1:0]      target_wide;
   logic [WIDE_W-1:0]      fill_wide;

   logic                    is_insert;
   logic                    full;
   logic                    issue;
   logic                    match;
   logic                    cmp_last;
   logic                    scan_done;
   logic [KEY_WIDTH-1:0]    rd_key;
   logic [HANDLE_WIDTH-1:0] rd_handle;
   logic [HITS_W-1:0]       rd_hits;
   logic [STAMP_W-1:0]      rd_stamp;
   logic [HANDLE_WIDTH-1:0] wr_handle;
   logic [HITS_W-1:0]       wr_hits;
   logic [HITS_W-1:0]       resp_hits;

   lkct_ram #(
      .WIDTH  (WORD_W),
      .DEPTH  (ENTRIES),
      .ADDR_W (IDX_W)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (target_ff),
      .wr_data (ram_wr_data),
      .rd_addr (rd_idx_ff[IDX_W-1:0]),
      .rd_data (ram_rd_data)
   );

   // Field extraction and resizing
   assign req_key_wide    = req_key;
   assign req_handle_wide = 64'(req_data_handle);
   assign rd_key    = ram_rd_data[KEY_LO    +: KEY_WIDTH];
   assign rd_handle = ram_rd_data[HANDLE_LO +: HANDLE_WIDTH];
   assign rd_hits   = ram_rd_data[HITS_LO   +: HITS_W];
   assign rd_stamp  = ram_rd_data[STAMP_LO  +: STAMP_W];

   assign is_insert = (op_ff == OP_INSERT);
   assign full      = (filled_ff == FULL_COUNT);

   // Scan: one read issued per cycle, its data compared in the next cycle
   assign issue     = cmd.issue_en && (rd_idx_ff < filled_ff) && !scan_done;
   assign match     = cmp_valid_ff && !is_insert && (rd_key == key_ff);
   assign cmp_last  = cmp_valid_ff && (cmp_idx_ff == filled_ff - 1'b1);
   assign scan_done = cmd.compare_en && (match || cmp_last);

   // Write data: an insert writes its key and handle with a count of 1; a hit rewrites the slot with its count bumped
   assign wr_handle   = is_insert ? handle_ff : found_handle_ff;
   assign wr_hits     = is_insert ? HITS_W'(1) : found_hits_ff + 1'b1;
   assign ram_wr_en   = cmd.write_en;
   assign ram_wr_data = {stamp_ff, wr_hits, wr_handle, key_ff};

   // Status to controller
   assign status.need_scan    = is_insert ? full : (filled_ff != '0);
   assign status.direct_write = is_insert && !full;
   assign status.scan_done    = scan_done;
   assign status.scan_write   = scan_done && (match || is_insert);
   assign status.rsp_free     = !rsp_valid_ff || rsp_ready;
   assign status.full         = full;

   // Next-state logic
   always_comb begin
      filled_in       = filled_ff;
      stamp_in        = stamp_ff;
      rd_idx_in       = rd_idx_ff;
      cmp_valid_in    = issue;
      best_idx_in     = best_idx_ff;
      best_stamp_in   = best_stamp_ff;
      found_in        = found_ff;
      found_handle_in = found_handle_ff;
      found_hits_in   = found_hits_ff;
      target_in       = target_ff;
      replaced_in     = replaced_ff;

      if (cmd.accept) begin
         rd_idx_in = '0;
         found_in  = 1'b0;
         target_in = '0;
      end
      if (issue) begin
         rd_idx_in = rd_idx_ff + 1'b1;
      end
      if (cmd.start) begin
         replaced_in = is_insert && full;
         if (is_insert && !full) begin
            target_in = filled_ff[IDX_W-1:0];
         end
      end

      // Oldest stamp: strict compare keeps the lowest index on a tie
      if (cmd.compare_en && cmp_valid_ff && is_insert) begin
         if ((cmp_idx_ff == '0) || (rd_stamp < best_stamp_ff)) begin
            best_idx_in   = cmp_idx_ff[IDX_W-1:0];
            best_stamp_in = rd_stamp;
         end
      end
      if (cmd.compare_en && match) begin
         found_in        = 1'b1;
         found_handle_in = rd_handle;
         found_hits_in   = rd_hits;
         target_in       = cmp_idx_ff[IDX_W-1:0];
      end
      if (scan_done && is_insert) begin
         target_in = best_idx_in;
      end

      if (cmd.write_en) begin
         stamp_in = stamp_ff + 1'b1;
         if (is_insert && !full) begin
            filled_in = filled_ff + 1'b1;
         end
      end
   end

   // Response fields
   assign found_handle_wide = 64'(found_handle_ff);
   assign target_wide       = WIDE_W'(target_ff);
   assign fill_wide         = WIDE_W'(filled_ff);
   assign resp_hits = is_insert ? HITS_W'(1) :
                      (found_ff ? found_hits_ff + 1'b1 : '0);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         filled_ff    <= '0;
         stamp_ff     <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         filled_ff    <= filled_in;
         stamp_ff     <= stamp_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff     <= req_opcode;
         key_ff    <= req_key_wide[KEY_WIDTH-1:0];
         handle_ff <= req_handle_wide[HANDLE_WIDTH-1:0];
      end
      rd_idx_ff       <= rd_idx_in;
      cmp_idx_ff      <= rd_idx_ff;
      best_idx_ff     <= best_idx_in;
      best_stamp_ff   <= best_stamp_in;
      found_ff        <= found_in;
      found_handle_ff <= found_handle_in;
      found_hits_ff   <= found_hits_in;
      target_ff       <= target_in;
      replaced_ff     <= replaced_in;
      if (cmd.finish) begin
         rsp_hit_ff  <= !is_insert && found_ff;
         rsp_data_ff <= (!is_insert && found_ff) ?
                        found_handle_wide[HANDLE_FIELD_W-1:0] : '0;
         rsp_hits_ff <= resp_hits;
         rsp_slot_ff <= target_wide[SLOT_FIELD_W-1:0];
         rsp_repl_ff <= replaced_ff;
         rsp_fill_ff <= fill_wide[FILL_FIELD_W-1:0];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_data_out   = rsp_data_ff;
   assign rsp_entry_hits = rsp_hits_ff;
   assign rsp_slot       = rsp_slot_ff;
   assign rsp_replaced   = rsp_repl_ff;
   assign rsp_fill_level = rsp_fill_ff;

endmodule

@@ test/tb_lru_keyed_cache_table_core.sv @@
`timescale 1ns / 100ps
// Self-checking bench for lru_keyed_cache_table_core: lookups and inserts are
// predicted against a behavioural copy of the LRU table and checked per field.
// Depends on lkct_pkg, lkct_req_if, lkct_rsp_if and the core RTL.
module tb_lru_keyed_cache_table_core;
   import lkct_pkg::*;

   localparam int SLOTS        = DEF_ENTRIES;
   localparam int GAP_MAX      = 17;
   localparam int DRAIN_CYCLES = 80;
   localparam int POOL_DEPTH   = 96;
   localparam int RANDOM_ITEMS = 1250;

   typedef struct {
      logic [OPCODE_W-1:0]       opcode;
      logic [KEY_FIELD_W-1:0]    key;
      logic [HANDLE_FIELD_W-1:0] handle;
   } cache_req_type;

   typedef struct {
      logic                      hit;
      logic [HANDLE_FIELD_W-1:0] data_out;
      logic [HITS_W-1:0]         entry_hits;
      logic [SLOT_FIELD_W-1:0]   slot;
      logic                      replaced;
      logic [FILL_FIELD_W-1:0]   fill_level;
   } cache_rsp_type;

   logic clock;
   logic reset;

   lkct_req_if req_chan();
   lkct_rsp_if rsp_chan();

   lru_keyed_cache_table_core i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Shadow copy of the table
   logic [KEY_FIELD_W-1:0]    table_keys    [SLOTS];
   logic [HANDLE_FIELD_W-1:0] table_handles [SLOTS];
   logic [HITS_W-1:0]         table_hits    [SLOTS];
   logic [STAMP_W-1:0]        table_stamps  [SLOTS];
   int                        table_fill = 0;
   logic [STAMP_W-1:0]        stamp_now  = '0;

   cache_req_type pending_reqs [$];
   cache_rsp_type expected_rsps[$];
   logic [KEY_FIELD_W-1:0] key_pool[$];
   int mismatches = 0;

   // Handshake bookkeeping
   logic          req_fire = 1'b0;
   logic          rsp_fire = 1'b0;
   logic          req_busy = 1'b0;
   logic          req_calm = 1'b0;
   logic          rsp_calm = 1'b0;
   int            req_gap  = 0;
   int            rsp_wait = 0;
   cache_req_type next_req;
   cache_req_type taken_req;
   cache_rsp_type got_rsp;
   cache_rsp_type want_rsp;
   cache_rsp_type lru_rsp;

   function automatic cache_req_type make_req(input logic [OPCODE_W-1:0] op,
                                              input logic [KEY_FIELD_W-1:0] k,
                                              input logic [HANDLE_FIELD_W-1:0] h);
      cache_req_type r;
      r.opcode = op;
      r.key    = k;
      r.handle = h;
      return r;
   endfunction

   // Calm stretches give back-to-back traffic, otherwise a random idle gap is drawn
   function automatic int idle_draw(input logic calm);
      return calm ? 0 : $urandom_range(0, GAP_MAX);
   endfunction

   // LRU table behaviour: scan for hit, or fill / evict on insert
   task automatic lru_update(input cache_req_type r, output cache_rsp_type res);
      int victim;
      res = '{default: '0};
      if (r.opcode == OP_LOOKUP) begin
         for (int i = 0; i < table_fill && !res.hit; i++) begin
            if (table_keys[i] == r.key) begin
               table_hits[i]   = table_hits[i] + 1'b1;
               table_stamps[i] = stamp_now;
               stamp_now       = stamp_now + 1'b1;
               res.hit         = 1'b1;
               res.data_out    = table_handles[i];
               res.entry_hits  = table_hits[i];
               res.slot        = i[SLOT_FIELD_W-1:0];
            end
         end
      end else begin
         if (table_fill >= SLOTS) begin
            // oldest stamp wins, lowest index on a tie
            victim = 0;
            for (int i = 1; i < table_fill; i++) begin
               if (table_stamps[i] < table_stamps[victim]) victim = i;
            end
            res.replaced = 1'b1;
         end else begin
            victim     = table_fill;
            table_fill = table_fill + 1;
         end
         table_keys[victim]    = r.key;
         table_handles[victim] = r.handle;
         table_hits[victim]    = 1;
         table_stamps[victim]  = stamp_now;
         stamp_now             = stamp_now + 1'b1;
         res.entry_hits        = 1;
         res.slot              = victim[SLOT_FIELD_W-1:0];
      end
      res.fill_level = table_fill[FILL_FIELD_W-1:0];
   endtask

   task automatic compare_field(input string fname, input logic [63:0] want,
                                input logic [63:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: %s expected 0x%0h, actual 0x%0h", $time, fname, want, got);
      end
   endtask

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog
   initial begin
      #10_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Request driver: one transaction at a time, gap drawn after each
   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         req_busy = 1'b0;
         req_gap  = 0;
      end else begin
         if (req_busy && req_fire) begin
            req_busy = 1'b0;
            if ($urandom_range(0, 31) == 0) req_calm = !req_calm;
            req_gap = idle_draw(req_calm);
         end
         if (!req_busy) begin
            if (req_gap > 0) begin
               req_gap--;
            end else if (pending_reqs.size() != 0) begin
               next_req = pending_reqs.pop_front();
               req_chan.opcode      <= next_req.opcode;
               req_chan.key         <= next_req.key;
               req_chan.data_handle <= next_req.handle;
               req_busy = 1'b1;
            end
         end
         req_chan.valid <= req_busy;
      end
   end

   // Response ready: stall counts down only while a response is offered
   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         rsp_wait = idle_draw(rsp_calm);
      end else begin
         if (rsp_fire) begin
            if ($urandom_range(0, 31) == 0) rsp_calm = !rsp_calm;
            rsp_wait = idle_draw(rsp_calm);
         end
         if (rsp_wait > 0 && rsp_chan.valid) rsp_wait--;
         rsp_chan.ready <= (rsp_wait == 0);
      end
   end

   // Monitor: check responses first, then predict the accepted request
   always @(posedge clock) begin
      if (reset) begin
         req_fire <= 1'b0;
         rsp_fire <= 1'b0;
      end else begin
         req_fire <= req_chan.valid && req_chan.ready;
         rsp_fire <= rsp_chan.valid && rsp_chan.ready;
         if (rsp_chan.valid && rsp_chan.ready) begin
            got_rsp.hit        = rsp_chan.hit;
            got_rsp.data_out   = rsp_chan.data_out;
            got_rsp.entry_hits = rsp_chan.entry_hits;
            got_rsp.slot       = rsp_chan.slot;
            got_rsp.replaced   = rsp_chan.replaced;
            got_rsp.fill_level = rsp_chan.fill_level;
            if (expected_rsps.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected response, expected none, actual hit=%0d slot=%0d",
                        $time, got_rsp.hit, got_rsp.slot);
            end else begin
               want_rsp = expected_rsps.pop_front();
               compare_field("hit",        64'(want_rsp.hit),        64'(got_rsp.hit));
               compare_field("data_out",   64'(want_rsp.data_out),   64'(got_rsp.data_out));
               compare_field("entry_hits", 64'(want_rsp.entry_hits),
                             64'(got_rsp.entry_hits));
               compare_field("slot",       64'(want_rsp.slot),       64'(got_rsp.slot));
               compare_field("replaced",   64'(want_rsp.replaced),   64'(got_rsp.replaced));
               compare_field("fill_level", 64'(want_rsp.fill_level),
                             64'(got_rsp.fill_level));
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            taken_req.opcode = req_chan.opcode;
            taken_req.key    = req_chan.key;
            taken_req.handle = req_chan.data_handle;
            lru_update(taken_req, lru_rsp);
            expected_rsps.push_back(lru_rsp);
         end
      end
   end

   // Stimulus, reset and end of run
   initial begin
      logic [KEY_FIELD_W-1:0] k;
      int pick;
      int kind;

      reset                = 1'b1;
      req_chan.valid       = 1'b0;
      req_chan.opcode      = OP_LOOKUP;
      req_chan.key         = '0;
      req_chan.data_handle = '0;
      rsp_chan.ready       = 1'b0;

      // Directed: empty-table misses, field extremes, repeat hits,
      // ignored handle on lookup, duplicate key (first slot wins)
      pending_reqs.push_back(make_req(OP_LOOKUP, '0, '0));
      pending_reqs.push_back(make_req(OP_LOOKUP, '1, '1));
      pending_reqs.push_back(make_req(OP_INSERT, '0, '0));
      pending_reqs.push_back(make_req(OP_INSERT, '1, '1));
      pending_reqs.push_back(make_req(OP_LOOKUP, '0, '1));
      pending_reqs.push_back(make_req(OP_LOOKUP, '1, '0));
      pending_reqs.push_back(make_req(OP_LOOKUP, '1, 32'h1234_5678));
      pending_reqs.push_back(make_req(OP_LOOKUP, 64'h5555_5555_5555_5555, '0));
      pending_reqs.push_back(make_req(OP_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555));
      pending_reqs.push_back(make_req(OP_INSERT, 64'h5555_5555_5555_5555, 32'hAAAA_AAAA));
      pending_reqs.push_back(make_req(OP_INSERT, '0, 32'hA5A5_A5A5));
      pending_reqs.push_back(make_req(OP_LOOKUP, '0, '0));
      pending_reqs.push_back(make_req(OP_LOOKUP, 64'h5555_5555_5555_5555, '1));
      pending_reqs.push_back(make_req(OP_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAA, '0));
      pending_reqs.push_back(make_req(OP_LOOKUP, 64'h8000_0000_0000_0001, '0));
      key_pool.push_back('0);
      key_pool.push_back('1);
      key_pool.push_back(64'hAAAA_AAAA_AAAA_AAAA);
      key_pool.push_back(64'h5555_5555_5555_5555);

      // Random: inserts fill then churn the table, lookups mostly reuse
      // recent keys so hits, misses on evicted keys and duplicates all occur
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         pick = $urandom_range(0, 99);
         kind = $urandom_range(0, 99);
         if (pick < 40) begin
            if (kind < 70)      k = {$urandom, $urandom};
            else if (kind < 85) k = 64'($urandom_range(0, 15));
            else                k = key_pool[$urandom_range(0, key_pool.size() - 1)];
            pending_reqs.push_back(make_req(OP_INSERT, k, $urandom));
            key_pool.push_back(k);
            if (key_pool.size() > POOL_DEPTH) void'(key_pool.pop_front());
         end else begin
            if (kind < 75)      k = key_pool[$urandom_range(0, key_pool.size() - 1)];
            else if (kind < 85) k = 64'($urandom_range(0, 15));
            else                k = {$urandom, $urandom};
            pending_reqs.push_back(make_req(OP_LOOKUP, k, $urandom));
         end
      end

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (pending_reqs.size() != 0 || req_busy || expected_rsps.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (expected_rsps.size() != 0)
         $display("%0t: %0d responses never arrived", $time, expected_rsps.size());
      if (mismatches == 0 && expected_rsps.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
